// ----- hw/rtl/bounded_array_list_engine_assert.svh -----
// assertion macros shared by the engine modules
// each macro samples on i_clk and is held off while i_rst_n is low
`ifndef BOUNDED_ARRAY_LIST_ENGINE_ASSERT_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BALE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define BALE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define BALE_ASSERT_IMPL(label, ante, cons)
`define BALE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- hw/rtl/bale_pkg.sv -----
package bale_pkg;

    localparam int BALE_DEPTH  = 256;
    localparam int OP_W        = 3;
    localparam int IDX_W       = 8;
    localparam int VAL_W       = 32;
    localparam int ST_W        = 2;
    localparam int CNT_OUT_W   = 9;

    typedef enum logic [OP_W-1:0] {
        OP_READ   = 3'd0,
        OP_WRITE  = 3'd1,
        OP_APPEND = 3'd2,
        OP_POP    = 3'd3,
        OP_LAST   = 3'd4,
        OP_INSERT = 3'd5,
        OP_DELETE = 3'd6,
        OP_NONE   = 3'd7
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RDWAIT,
        S_SHIFT,
        S_DRAIN,
        S_PLACE,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;        // latch request fields
        logic judge;       // capture status of the request
        logic fetch;       // single read at index or last
        logic store;       // single write of request value
        logic shift_init;  // set up the move pointer
        logic shift_step;  // read at pointer, write previous beat
        logic shift_drain; // write the final moved entry
        logic cnt_inc;
        logic cnt_dec;
        logic grab;        // capture read data as result
        logic emit;        // result strobe
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_op     op;
        t_status err;
        logic    shift_last;
        logic    shift_none;
    } t_sts;

endpackage

// ----- hw/rtl/bale_ram.sv -----
module bale_ram import bale_pkg::*; #(
    parameter int WIDTH = VAL_W,
    parameter int DEPTH = BALE_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- hw/rtl/bale_ctrl.sv -----
`include "bounded_array_list_engine_assert.svh"

module bale_ctrl import bale_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.err != ST_OK) begin
                    n_state = S_DONE;
                end else begin
                    unique case (i_sts.op)
                        OP_READ, OP_POP, OP_LAST: n_state = S_RDWAIT;
                        OP_INSERT:                n_state = S_SHIFT;
                        OP_DELETE:                n_state = i_sts.shift_none ? S_DONE : S_SHIFT;
                        default:                  n_state = S_DONE;
                    endcase
                end
            end
            S_RDWAIT: n_state = S_DONE;
            S_SHIFT: begin
                if (i_sts.shift_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN:  n_state = (i_sts.op == OP_INSERT) ? S_PLACE : S_DONE;
            S_PLACE:  n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_start;
            end
            S_CHECK: begin
                o_cmd.judge = 1'b1;
                if (i_sts.err == ST_OK) begin
                    unique case (i_sts.op)
                        OP_READ, OP_LAST: o_cmd.fetch = 1'b1;
                        OP_POP: begin
                            o_cmd.fetch   = 1'b1;
                            o_cmd.cnt_dec = 1'b1;
                        end
                        OP_WRITE: o_cmd.store = 1'b1;
                        OP_APPEND: begin
                            o_cmd.store   = 1'b1;
                            o_cmd.cnt_inc = 1'b1;
                        end
                        OP_INSERT: o_cmd.shift_init = 1'b1;
                        OP_DELETE: begin
                            o_cmd.shift_init = !i_sts.shift_none;
                            o_cmd.cnt_dec    = i_sts.shift_none;
                        end
                        default: ;
                    endcase
                end
            end
            S_RDWAIT: o_cmd.grab = 1'b1;
            S_SHIFT:  o_cmd.shift_step = 1'b1;
            S_DRAIN: begin
                o_cmd.shift_drain = 1'b1;
                o_cmd.cnt_dec     = (i_sts.op == OP_DELETE);
            end
            S_PLACE: begin
                o_cmd.store   = 1'b1;
                o_cmd.cnt_inc = 1'b1;
            end
            S_DONE:  o_cmd.emit = 1'b1;
            default: ;
        endcase
    end

    `BALE_ASSERT_NEXT(a_emit_then_idle, o_cmd.emit, !o_busy)
    `BALE_ASSERT_IMPL(a_load_only_idle, o_cmd.load, !o_busy)
    `BALE_ASSERT_IMPL(a_cnt_one_way, 1'b1, !(o_cmd.cnt_inc && o_cmd.cnt_dec))

endmodule

// ----- hw/rtl/bale_dp.sv -----
`include "bounded_array_list_engine_assert.svh"

module bale_dp import bale_pkg::*; #(
    parameter int DEPTH = BALE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic [OP_W-1:0]      i_opcode,
    input  logic [IDX_W-1:0]     i_index,
    input  logic [VAL_W-1:0]     i_value,
    output logic [VAL_W-1:0]     o_read_value,
    output logic [ST_W-1:0]      o_status,
    output logic [CNT_OUT_W-1:0] o_element_count
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

    t_op              r_op;
    logic [IDX_W-1:0] r_idx;
    logic [VAL_W-1:0] r_val;
    logic [CW-1:0]    r_cnt;
    logic [AW-1:0]    r_ptr;
    logic [AW-1:0]    r_wa;
    logic             r_wpend;
    logic [VAL_W-1:0] r_rd;
    t_status          r_st;

    logic [CMPW-1:0]  idx_ext;
    logic [CMPW-1:0]  cnt_ext;
    logic             idx_ok;
    logic             full;
    logic             empty;
    logic [AW-1:0]    idx_a;
    logic [AW-1:0]    cnt_a;
    logic [AW-1:0]    last_a;
    t_status          err;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [VAL_W-1:0] ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [VAL_W-1:0] ram_rdata;

    assign idx_ext = CMPW'(r_idx);
    assign cnt_ext = CMPW'(r_cnt);
    assign idx_ok  = idx_ext < cnt_ext;
    assign full    = (r_cnt == CW'(DEPTH));
    assign empty   = (r_cnt == '0);
    assign idx_a   = AW'(r_idx);
    assign cnt_a   = AW'(r_cnt);
    assign last_a  = AW'(r_cnt - CW'(1));

    always_comb begin
        err = ST_OK;
        unique case (r_op)
            OP_READ, OP_WRITE, OP_DELETE: err = idx_ok ? ST_OK : ST_RANGE;
            OP_INSERT: begin
                if (!idx_ok) begin
                    err = ST_RANGE;
                end else if (full) begin
                    err = ST_FULL;
                end
            end
            OP_APPEND:      err = full ? ST_FULL : ST_OK;
            OP_POP, OP_LAST: err = empty ? ST_EMPTY : ST_OK;
            default:        err = ST_OK;
        endcase
    end

    assign o_sts.op         = r_op;
    assign o_sts.err        = err;
    assign o_sts.shift_none = ((idx_ext + CMPW'(1)) == cnt_ext);
    assign o_sts.shift_last = (r_op == OP_INSERT) ? (r_ptr == idx_a) : (r_ptr == last_a);

    // store port: request value wins, else the pending moved entry
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_wa;
        ram_wdata = ram_rdata;
        if (i_cmd.store) begin
            ram_we    = 1'b1;
            ram_waddr = (r_op == OP_APPEND) ? cnt_a : idx_a;
            ram_wdata = r_val;
        end else if (r_wpend && (i_cmd.shift_step || i_cmd.shift_drain)) begin
            ram_we = 1'b1;
        end
    end

    assign ram_raddr = i_cmd.fetch ? ((r_op == OP_READ) ? idx_a : last_a) : r_ptr;

    bale_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_wpend <= 1'b0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_cnt <= r_cnt - CW'(1);
            end
            if (i_cmd.shift_init || i_cmd.shift_drain) begin
                r_wpend <= 1'b0;
            end else if (i_cmd.shift_step) begin
                r_wpend <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_op'(i_opcode);
            r_idx <= i_index;
            r_val <= i_value;
            r_rd  <= '0;
        end
        if (i_cmd.grab) begin
            r_rd <= ram_rdata;
        end
        if (i_cmd.judge) begin
            r_st <= err;
        end
        if (i_cmd.shift_init) begin
            r_ptr <= (r_op == OP_INSERT) ? last_a : (idx_a + AW'(1));
        end else if (i_cmd.shift_step) begin
            r_ptr <= (r_op == OP_INSERT) ? (r_ptr - AW'(1)) : (r_ptr + AW'(1));
            r_wa  <= (r_op == OP_INSERT) ? (r_ptr + AW'(1)) : (r_ptr - AW'(1));
        end
    end

    assign o_read_value    = r_rd;
    assign o_status        = r_st;
    assign o_element_count = CNT_OUT_W'(r_cnt);

    `BALE_ASSERT_IMPL(a_cnt_bound, 1'b1, r_cnt <= CW'(DEPTH))
    `BALE_ASSERT_NEXT(a_err_keeps_cnt, i_cmd.judge && (err != ST_OK), r_cnt == $past(r_cnt))
    `BALE_ASSERT_IMPL(a_no_port_clash, i_cmd.store, !(r_wpend && i_cmd.shift_drain))

endmodule

// ----- hw/rtl/bounded_array_list_engine.sv -----
// channel   | direction | beat marked by      | fields
// ----------+-----------+---------------------+------------------------------------------
// request   | in        | start high, busy low| i_opcode, i_index, i_value
// result    | out       | o_done for 1 cycle  | o_read_value, o_status, o_element_count
//
// busy drops the cycle after the strobe. the move loop of insert and delete is set by the
// single store write port: one entry moves per cycle, so the longest insert is at index 0
// with the list one short of full.
// reset (i_rst_n low, synchronous) empties the list; the store itself is not cleared.
// the receiver cannot stall: it is to take each result in the strobe cycle (not enforced here).
module bounded_array_list_engine import bale_pkg::*; #(
    parameter int DEPTH = BALE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [OP_W-1:0]      i_opcode,
    input  logic [IDX_W-1:0]     i_index,
    input  logic [VAL_W-1:0]     i_value,
    output logic                 o_done,
    output logic [VAL_W-1:0]     o_read_value,
    output logic [ST_W-1:0]      o_status,
    output logic [CNT_OUT_W-1:0] o_element_count
);

    // command and status between the sequencer and the list datapath
    t_cmd cmd;
    t_sts sts;

    // sequencer: accepts a request, checks it, then runs the access or the move loop
    bale_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // datapath: request registers, live count, move pointers and the element store
    bale_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_opcode        (i_opcode),
        .i_index         (i_index),
        .i_value         (i_value),
        .o_read_value    (o_read_value),
        .o_status        (o_status),
        .o_element_count (o_element_count)
    );

    // result beat strobe comes straight from the done state
    assign o_done = cmd.emit;

endmodule
